// ===== rtl/aarm_pkg.sv =====
// aarm_pkg: shared widths, fixed-point constants, cordic arctangent table,
// axis struct and the output rounding/saturation function
// no dependencies
`default_nettype none

package aarm_pkg;

  localparam int CORDIC_STEPS_DEF = 16;
  localparam int ATAN_COUNT       = 30;

  // data widths
  localparam int FW  = 16;                 // field width
  localparam int ZW  = 32;                 // angle path, q.28
  localparam int XW  = 34;                 // cordic x/y, q.30
  localparam int PPW = 2 * FW;             // axis pair product
  localparam int MW  = PPW + XW;           // pair * (1 - c)
  localparam int KW  = FW + XW;            // axis * s
  localparam int SW  = MW + 2;             // entry sum, q.58
  localparam int RSH = 44;                 // q.58 -> q.14

  localparam logic signed [ZW-1:0] ANG_PI      = 32'sd843314857;
  localparam logic signed [ZW-1:0] ANG_HALF_PI = 32'sd421657428;
  localparam logic signed [XW-1:0] CORDIC_GAIN = 34'sd652032874;
  localparam logic signed [XW-1:0] ONE_Q30     = 34'sd1073741824;

  typedef struct packed {
    logic signed [FW-1:0] x;
    logic signed [FW-1:0] y;
    logic signed [FW-1:0] z;
  } aarm_axis_t;

  // round(atan(2^-i) * 2^28)
  function automatic logic signed [ZW-1:0] atan_q28(input int idx);
    logic signed [ZW-1:0] v;
    case (idx)
      0:  v = 32'sd210828714;
      1:  v = 32'sd124459457;
      2:  v = 32'sd65760959;
      3:  v = 32'sd33381290;
      4:  v = 32'sd16755422;
      5:  v = 32'sd8385879;
      6:  v = 32'sd4193963;
      7:  v = 32'sd2097109;
      8:  v = 32'sd1048571;
      9:  v = 32'sd524287;
      10: v = 32'sd262144;
      11: v = 32'sd131072;
      12: v = 32'sd65536;
      13: v = 32'sd32768;
      14: v = 32'sd16384;
      15: v = 32'sd8192;
      16: v = 32'sd4096;
      17: v = 32'sd2048;
      18: v = 32'sd1024;
      19: v = 32'sd512;
      20: v = 32'sd256;
      21: v = 32'sd128;
      22: v = 32'sd64;
      23: v = 32'sd32;
      24: v = 32'sd16;
      25: v = 32'sd8;
      26: v = 32'sd4;
      27: v = 32'sd2;
      28: v = 32'sd1;
      default: v = '0;
    endcase
    return v;
  endfunction

  // round half up from q.58 to q.14, then clamp to 16 bits
  function automatic logic signed [FW-1:0] round_sat(input logic signed [SW-1:0] v);
    logic signed [SW-1:0]     t;
    logic signed [SW-RSH-1:0] r;
    logic signed [FW-1:0]     res;
    t = v + (SW'(1) <<< (RSH - 1));
    r = t[SW-1:RSH];
    if (r > (SW-RSH)'(32767)) begin
      res = 16'sd32767;
    end else if (r < -(SW-RSH)'(32768)) begin
      res = -16'sd32768;
    end else begin
      res = r[FW-1:0];
    end
    return res;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/aarm_cordic.sv =====
// aarm_cordic: half-turn angle reduction and a pipelined cordic rotator,
// one register stage per iteration; the axis rides along as a side payload
// depends on aarm_pkg
`default_nettype none

module aarm_cordic #(
  parameter int STEPS = aarm_pkg::CORDIC_STEPS_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   en,
  input  logic                                   in_valid,
  input  logic signed [aarm_pkg::FW-1:0]         angle,
  input  aarm_pkg::aarm_axis_t                   in_axis,
  output logic                                   out_valid,
  output logic                                   out_neg,
  output logic signed [aarm_pkg::XW-1:0]         out_x,
  output logic signed [aarm_pkg::XW-1:0]         out_y,
  output aarm_pkg::aarm_axis_t                   out_axis
);
  import aarm_pkg::*;

  logic signed [ZW-1:0] z_in;
  logic signed [ZW-1:0] z0_nxt;
  logic                 neg0_nxt;

  logic                 v_r    [0:STEPS];
  logic                 neg_r  [0:STEPS];
  logic signed [XW-1:0] x_r    [0:STEPS];
  logic signed [XW-1:0] y_r    [0:STEPS];
  logic signed [ZW-1:0] z_r    [0:STEPS];
  aarm_axis_t           axis_r [0:STEPS];

  // angle in q.28
  assign z_in = {angle[FW-1], angle, 15'd0};

  always_comb begin
    z0_nxt   = z_in;
    neg0_nxt = 1'b0;
    if (z_in > ANG_HALF_PI) begin
      z0_nxt   = z_in - ANG_PI;
      neg0_nxt = 1'b1;
    end else if (z_in < -ANG_HALF_PI) begin
      z0_nxt   = z_in + ANG_PI;
      neg0_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else if (en) begin
      v_r[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      neg_r[0]  <= neg0_nxt;
      x_r[0]    <= CORDIC_GAIN;
      y_r[0]    <= '0;
      z_r[0]    <= z0_nxt;
      axis_r[0] <= in_axis;
    end
  end

  for (genvar i = 0; i < STEPS; i++) begin : g_iter
    logic signed [XW-1:0] x_nxt;
    logic signed [XW-1:0] y_nxt;
    logic signed [ZW-1:0] z_nxt;

    always_comb begin
      if (z_r[i] >= 0) begin
        x_nxt = x_r[i] - (y_r[i] >>> i);
        y_nxt = y_r[i] + (x_r[i] >>> i);
        z_nxt = z_r[i] - atan_q28(i);
      end else begin
        x_nxt = x_r[i] + (y_r[i] >>> i);
        y_nxt = y_r[i] - (x_r[i] >>> i);
        z_nxt = z_r[i] + atan_q28(i);
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[i+1] <= 1'b0;
      end else if (en) begin
        v_r[i+1] <= v_r[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        neg_r[i+1]  <= neg_r[i];
        x_r[i+1]    <= x_nxt;
        y_r[i+1]    <= y_nxt;
        z_r[i+1]    <= z_nxt;
        axis_r[i+1] <= axis_r[i];
      end
    end
  end

  assign out_valid = v_r[STEPS];
  assign out_neg   = neg_r[STEPS];
  assign out_x     = x_r[STEPS];
  assign out_y     = y_r[STEPS];
  assign out_axis  = axis_r[STEPS];

endmodule

`default_nettype wire

// ===== rtl/axis_angle_rotation_matrix.sv =====
// throughput: one beat per cycle; one register stage per cordic iteration
// plus angle reduction, sign fix, multiply, sum and round stages
// a one-entry skid holds a stalled result; the pipeline freezes while it is full
// rst_n (synchronous, active low) clears valid bits and the skid, not payload
// depends on aarm_pkg and aarm_cordic
`default_nettype none

module axis_angle_rotation_matrix #(
  parameter int CORDIC_STEPS = aarm_pkg::CORDIC_STEPS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic signed [aarm_pkg::FW-1:0]  in_axis_x,
  input  logic signed [aarm_pkg::FW-1:0]  in_axis_y,
  input  logic signed [aarm_pkg::FW-1:0]  in_axis_z,
  input  logic signed [aarm_pkg::FW-1:0]  in_angle,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic signed [aarm_pkg::FW-1:0]  out_col0_row0,
  output logic signed [aarm_pkg::FW-1:0]  out_col0_row1,
  output logic signed [aarm_pkg::FW-1:0]  out_col0_row2,
  output logic signed [aarm_pkg::FW-1:0]  out_col1_row0,
  output logic signed [aarm_pkg::FW-1:0]  out_col1_row1,
  output logic signed [aarm_pkg::FW-1:0]  out_col1_row2,
  output logic signed [aarm_pkg::FW-1:0]  out_col2_row0,
  output logic signed [aarm_pkg::FW-1:0]  out_col2_row1,
  output logic signed [aarm_pkg::FW-1:0]  out_col2_row2
);
  import aarm_pkg::*;

  logic                 en;
  aarm_axis_t           axis_in;

  logic                 cv;
  logic                 cneg;
  logic signed [XW-1:0] cx;
  logic signed [XW-1:0] cy;
  aarm_axis_t           caxis;

  // sign fix and axis pair products
  logic                  v1_r;
  logic signed [XW-1:0]  c1_r, s1_r, cc1_r;
  logic signed [XW-1:0]  c1_nxt, s1_nxt, cc1_nxt;
  logic signed [PPW-1:0] pair_r [6];
  aarm_axis_t            axis1_r;

  // multiplies
  logic                  v2_r;
  logic signed [XW-1:0]  c2_r;
  logic signed [MW-1:0]  pc_r [6];
  logic signed [KW-1:0]  ks_r [3];

  // sums
  logic                  v3_r;
  logic signed [SW-1:0]  sum_r [9];
  logic signed [SW-1:0]  sum_nxt [9];
  logic signed [SW-1:0]  cq;
  logic signed [SW-1:0]  pcx [6];
  logic signed [SW-1:0]  ksx [3];

  // result and skid
  logic                  res_v_r;
  logic signed [FW-1:0]  res_r [9];
  logic                  skid_v_r;
  logic signed [FW-1:0]  skid_r [9];
  logic signed [FW-1:0]  res_out [9];

  assign en       = !skid_v_r;
  assign in_ready = en;

  assign axis_in.x = in_axis_x;
  assign axis_in.y = in_axis_y;
  assign axis_in.z = in_axis_z;

  aarm_cordic #(
    .STEPS (CORDIC_STEPS)
  ) u_cordic (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (in_valid),
    .angle     (in_angle),
    .in_axis   (axis_in),
    .out_valid (cv),
    .out_neg   (cneg),
    .out_x     (cx),
    .out_y     (cy),
    .out_axis  (caxis)
  );

  always_comb begin
    if (cneg) begin
      c1_nxt  = -cx;
      s1_nxt  = -cy;
      cc1_nxt = ONE_Q30 + cx;
    end else begin
      c1_nxt  = cx;
      s1_nxt  = cy;
      cc1_nxt = ONE_Q30 - cx;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r    <= 1'b0;
      v2_r    <= 1'b0;
      v3_r    <= 1'b0;
      res_v_r <= 1'b0;
    end else if (en) begin
      v1_r    <= cv;
      v2_r    <= v1_r;
      v3_r    <= v2_r;
      res_v_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c1_r      <= c1_nxt;
      s1_r      <= s1_nxt;
      cc1_r     <= cc1_nxt;
      axis1_r   <= caxis;
      pair_r[0] <= PPW'(caxis.x) * PPW'(caxis.x);
      pair_r[1] <= PPW'(caxis.y) * PPW'(caxis.y);
      pair_r[2] <= PPW'(caxis.z) * PPW'(caxis.z);
      pair_r[3] <= PPW'(caxis.x) * PPW'(caxis.y);
      pair_r[4] <= PPW'(caxis.x) * PPW'(caxis.z);
      pair_r[5] <= PPW'(caxis.y) * PPW'(caxis.z);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c2_r <= c1_r;
      for (int k = 0; k < 6; k++) begin
        pc_r[k] <= MW'(pair_r[k]) * MW'(cc1_r);
      end
      ks_r[0] <= KW'(axis1_r.x) * KW'(s1_r);
      ks_r[1] <= KW'(axis1_r.y) * KW'(s1_r);
      ks_r[2] <= KW'(axis1_r.z) * KW'(s1_r);
    end
  end

  always_comb begin
    cq = SW'(c2_r) <<< 28;
    for (int k = 0; k < 6; k++) begin
      pcx[k] = SW'(pc_r[k]);
    end
    for (int k = 0; k < 3; k++) begin
      ksx[k] = SW'(ks_r[k]) <<< 14;
    end
    // pair order xx yy zz xy xz yz, sine terms x y z
    sum_nxt[0] = cq + pcx[0];
    sum_nxt[1] = pcx[3] + ksx[2];
    sum_nxt[2] = pcx[4] - ksx[1];
    sum_nxt[3] = pcx[3] - ksx[2];
    sum_nxt[4] = cq + pcx[1];
    sum_nxt[5] = pcx[5] + ksx[0];
    sum_nxt[6] = pcx[4] + ksx[1];
    sum_nxt[7] = pcx[5] - ksx[0];
    sum_nxt[8] = cq + pcx[2];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 9; k++) begin
        sum_r[k] <= sum_nxt[k];
        res_r[k] <= round_sat(sum_r[k]);
      end
    end
  end

  // skid entry catches the result beat when the sink stalls
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      skid_v_r <= 1'b0;
    end else if (skid_v_r) begin
      if (out_ready) begin
        skid_v_r <= 1'b0;
      end
    end else if (res_v_r && !out_ready) begin
      skid_v_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!skid_v_r) begin
      for (int k = 0; k < 9; k++) begin
        skid_r[k] <= res_r[k];
      end
    end
  end

  always_comb begin
    for (int k = 0; k < 9; k++) begin
      res_out[k] = skid_v_r ? skid_r[k] : res_r[k];
    end
  end

  assign out_valid     = skid_v_r | res_v_r;
  assign out_col0_row0 = res_out[0];
  assign out_col0_row1 = res_out[1];
  assign out_col0_row2 = res_out[2];
  assign out_col1_row0 = res_out[3];
  assign out_col1_row1 = res_out[4];
  assign out_col1_row2 = res_out[5];
  assign out_col2_row0 = res_out[6];
  assign out_col2_row1 = res_out[7];
  assign out_col2_row2 = res_out[8];

endmodule

`default_nettype wire

// ===== rtl/aarm_checker.sv =====
// aarm_checker: port-level checks on the rotation matrix block, bound to it
// depends on aarm_pkg and axis_angle_rotation_matrix
`default_nettype none

module aarm_checker (
  input wire logic                           clk,
  input wire logic                           rst_n,
  input wire logic                           in_ready,
  input wire logic                           out_valid,
  input wire logic                           out_ready,
  input wire logic signed [aarm_pkg::FW-1:0] out_col0_row0,
  input wire logic signed [aarm_pkg::FW-1:0] out_col1_row1,
  input wire logic signed [aarm_pkg::FW-1:0] out_col2_row2
);
  import aarm_pkg::*;

  // input side only blocks while a result beat is pending
  a_block_pending: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid)
    else $error("in_ready low with no result pending");

  // input side blocks only after a stalled result beat
  a_block_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(in_ready) |-> $past(out_valid && !out_ready))
    else $error("in_ready fell without an output stall");

  // reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("out_valid high after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result beat dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_col0_row0) && $stable(out_col1_row1)
      && $stable(out_col2_row2))
    else $error("result payload changed while stalled");

endmodule

bind axis_angle_rotation_matrix aarm_checker u_aarm_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_ready      (in_ready),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .out_col0_row0 (out_col0_row0),
  .out_col1_row1 (out_col1_row1),
  .out_col2_row2 (out_col2_row2)
);

`default_nettype wire
